// ===== rtl/core/fdr_pkg.sv =====
`timescale 1ns / 1ps
package fdr_pkg;

  localparam int CH_N  = 16;
  localparam int CH_W  = $clog2(CH_N);
  localparam int CNT_W = $clog2(CH_N + 1);

  // magnitude of (target - start) * step plus half, and the quotient
  localparam int NUM_W = 50;
  localparam int DIV_BITS = 2;
  localparam int DIV_ITER = NUM_W / DIV_BITS;
  localparam int ITER_W = $clog2(DIV_ITER);

  typedef enum logic [2:0] {
    OP_RETARGET  = 3'd0,
    OP_ADVANCE   = 3'd1,
    OP_SET_START = 3'd2,
    OP_SET_TGT   = 3'd3,
    OP_READ      = 3'd4,
    OP_MOVE      = 3'd5
  } fdr_op_t;

  typedef enum logic {
    REG_TOTAL_STEPS = 1'b0,
    REG_CHANNELS    = 1'b1
  } fdr_reg_t;

  typedef struct packed {
    logic [31:0] start_v;
    logic [31:0] target_v;
    logic [31:0] cur_v;
  } fdr_entry_t;

  typedef struct packed {
    logic [15:0]      eff_total;
    logic [CNT_W-1:0] n_chan;
  } fdr_cfg_t;

  typedef enum logic [2:0] {
    IS_IDLE,
    IS_MUL,
    IS_ABS,
    IS_DIV,
    IS_FIN
  } fdr_istate_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_EWAIT,
    ST_RGO,
    ST_RWAIT,
    ST_OUT
  } fdr_state_t;

endpackage

// ===== rtl/core/multichannel_linear_fader_top.sv =====
`timescale 1ns / 1ps
// read, set start and set target give their word without the interpolator; retarget
// runs one interpolation, an accepted advance or move one per channel in use; one word
// at a time, the next accepted once the result register is free. the per-channel cost
// is the 2-bit-per-cycle divider.
// synchronous active-low reset clears control state, step count and change flag;
// the channel store reads as zero until each entry is written.
module multichannel_linear_fader_top
  import fdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // channel[3:0], value[35:4], step_value[51:36], zero pad
  input  logic [2:0]  in_tuser,   // op[2:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // current_value[31:0]
  output logic [1:0]  out_tuser,  // done_res[0], rejected[1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] total_r;
  logic [4:0]  chans_r;
  fdr_cfg_t    cfg;
  logic        cfg_wr;
  fdr_reg_t    reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = fdr_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 16'd1;
      chans_r <= 5'd16;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TOTAL_STEPS: total_r <= cfg_pwdata[15:0];
        REG_CHANNELS:    chans_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TOTAL_STEPS: cfg_prdata = {16'd0, total_r};
      REG_CHANNELS:    cfg_prdata = {27'd0, chans_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // zero total behaves as one; channel count limited to the store depth
  assign cfg.eff_total = (total_r == '0) ? 16'd1 : total_r;
  assign cfg.n_chan    = ({1'b0, chans_r} > 6'(CH_N)) ? CNT_W'(CH_N) : CNT_W'(chans_r);

  fdr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_op(in_tuser),
    .in_ch(in_tdata[CH_W-1:0]), .in_val(in_tdata[35:4]), .in_sv(in_tdata[51:36]),
    .in_last(in_tlast),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_cur(out_tdata),
    .out_done(out_tuser[0]), .out_rej(out_tuser[1])
  );

endmodule

// ===== rtl/core/fdr_mem.sv =====
`timescale 1ns / 1ps
module fdr_mem
  import fdr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            we,
  input  logic [CH_W-1:0] waddr,
  input  fdr_entry_t      wdata,
  input  logic            re,
  input  logic [CH_W-1:0] raddr,
  output fdr_entry_t      rdata
);

  fdr_entry_t mem [CH_N];
  logic [CH_N-1:0] valid_r;
  fdr_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fdr_interp.sv =====
`timescale 1ns / 1ps
module fdr_interp
  import fdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] s_i,
  input  logic [31:0] t_i,
  input  logic [15:0] step_i,
  input  logic [15:0] tot_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  fdr_istate_t state_r, state_nxt;
  logic [31:0]        s_r, t_r, res_r, res_nxt;
  logic [15:0]        step_r, tot_r, rem_r, rem_nxt;
  logic               neg_r, done_r, done_nxt;
  logic signed [NUM_W-1:0] prod_r, prod_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [ITER_W-1:0]  cnt_r, cnt_nxt;

  logic signed [32:0] diff;
  logic [16:0]        sh;
  logic signed [NUM_W:0]   q;
  logic signed [NUM_W+1:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && state_r == IS_IDLE) begin
      s_r    <= s_i;
      t_r    <= t_i;
      step_r <= step_i;
      tot_r  <= tot_i;
    end
    if (state_r == IS_MUL) begin
      neg_r <= $signed(t_r) < $signed(s_r);
    end
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    diff      = $signed({t_r[31], t_r}) - $signed({s_r[31], s_r});
    sh        = '0;
    q         = '0;
    sum       = '0;
    case (state_r)
      IS_IDLE: begin
        if (go) state_nxt = IS_MUL;
      end
      IS_MUL: begin
        prod_nxt  = diff * $signed({1'b0, step_r});
        state_nxt = IS_ABS;
      end
      IS_ABS: begin
        // rounding: magnitude grows by half the total either way
        num_nxt   = (prod_r[NUM_W-1] ? NUM_W'(-prod_r) : NUM_W'(prod_r))
                    + {{(NUM_W-15){1'b0}}, tot_r[15:1]};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = IS_DIV;
      end
      IS_DIV: begin
        for (int k = 0; k < DIV_BITS; k++) begin
          sh      = {rem_nxt, num_nxt[NUM_W-1]};
          num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
          if (sh >= {1'b0, tot_r}) begin
            sh         = sh - {1'b0, tot_r};
            num_nxt[0] = 1'b1;
          end
          rem_nxt = sh[15:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ITER_W'(DIV_ITER - 1)) state_nxt = IS_FIN;
      end
      IS_FIN: begin
        q   = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
        sum = $signed({{(NUM_W-30){s_r[31]}}, s_r}) + $signed({q[NUM_W], q});
        if (sum > $signed((NUM_W+2)'(32'h7fff_ffff))) begin
          res_nxt = 32'h7fff_ffff;
        end else if (sum < -$signed((NUM_W+2)'(33'h0_8000_0000))) begin
          res_nxt = 32'h8000_0000;
        end else begin
          res_nxt = sum[31:0];
        end
        done_nxt  = 1'b1;
        state_nxt = IS_IDLE;
      end
      default: state_nxt = IS_IDLE;
    endcase
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

// ===== rtl/core/fdr_ctrl.sv =====
`timescale 1ns / 1ps
module fdr_ctrl
  import fdr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  fdr_cfg_t        cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_op,
  input  logic [CH_W-1:0] in_ch,
  input  logic [31:0]     in_val,
  input  logic [15:0]     in_sv,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_cur,
  output logic            out_done,
  output logic            out_rej
);

  fdr_state_t state_r, state_nxt;
  logic [2:0]        op_r;
  logic [CH_W-1:0]   ch_r;
  logic [31:0]       val_r;
  logic [15:0]       sv_r;
  logic              last_r;
  logic [15:0]       step_r, step_nxt;
  logic              chg_r, chg_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  fdr_entry_t        ent_r, ent_nxt;
  logic [31:0]       cur_r, cur_nxt;
  logic              rej_r, rej_nxt;
  logic              ov_r, ov_nxt;
  logic [31:0]       ocur_r;
  logic              odone_r, orej_r;

  logic              accept;
  logic              we, re, igo;
  logic [CH_W-1:0]   waddr, raddr;
  fdr_entry_t        wdata, rdata;
  logic [31:0]       is_s, is_t, ires;
  logic [15:0]       is_step;
  logic              idone;
  logic [31:0]       ns, nt, lo, hi;
  logic              diffv;

  fdr_mem u_mem (
    .clk(clk), .rst_n(rst_n), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  fdr_interp u_interp (
    .clk(clk), .rst_n(rst_n), .go(igo), .s_i(is_s), .t_i(is_t),
    .step_i(is_step), .tot_i(cfg.eff_total), .done_o(idone), .res_o(ires)
  );

  assign in_ready = (state_r == ST_IDLE) && (!ov_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      chg_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      chg_r   <= chg_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      ch_r   <= in_ch;
      val_r  <= in_val;
      sv_r   <= in_sv;
      last_r <= in_last;
    end
    idx_r <= idx_nxt;
    ent_r <= ent_nxt;
    cur_r <= cur_nxt;
    rej_r <= rej_nxt;
    if (state_r == ST_OUT) begin
      ocur_r  <= cur_r;
      orej_r  <= rej_r;
      odone_r <= step_r >= cfg.eff_total;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    chg_nxt   = chg_r;
    idx_nxt   = idx_r;
    ent_nxt   = ent_r;
    cur_nxt   = cur_r;
    rej_nxt   = rej_r;
    ov_nxt    = ov_r;
    we        = 1'b0;
    waddr     = ch_r;
    wdata     = ent_r;
    re        = 1'b0;
    raddr     = in_ch;
    igo       = 1'b0;
    is_s      = rdata.start_v;
    is_t      = rdata.target_v;
    is_step   = step_r;
    ns        = rdata.start_v;
    nt        = rdata.target_v;
    lo        = '0;
    hi        = '0;
    diffv     = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          re        = 1'b1;
          cur_nxt   = '0;
          rej_nxt   = 1'b0;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt = ST_OUT;
        case (op_r)
          OP_RETARGET: begin
            chg_nxt   = chg_r | (rdata.target_v != val_r);
            ent_nxt   = rdata;
            is_s      = rdata.cur_v;
            is_t      = val_r;
            is_step   = 16'd1;
            igo       = 1'b1;
            state_nxt = ST_EWAIT;
          end
          OP_SET_START, OP_SET_TGT: begin
            if (op_r == OP_SET_START) begin
              ns    = val_r;
              diffv = rdata.start_v != val_r;
            end else begin
              nt    = val_r;
              diffv = rdata.target_v != val_r;
            end
            lo = ($signed(ns) < $signed(nt)) ? ns : nt;
            hi = ($signed(ns) < $signed(nt)) ? nt : ns;
            we = 1'b1;
            wdata.start_v  = ns;
            wdata.target_v = nt;
            wdata.cur_v    = ($signed(rdata.cur_v) >= $signed(lo) &&
                              $signed(rdata.cur_v) <= $signed(hi)) ? rdata.cur_v : val_r;
            chg_nxt = chg_r | diffv;
            if (last_r) begin
              if (chg_nxt) step_nxt = (op_r == OP_SET_START) ? 16'd0 : cfg.eff_total;
              chg_nxt = 1'b0;
            end
          end
          OP_READ: cur_nxt = rdata.cur_v;
          OP_ADVANCE, OP_MOVE: begin
            if ((op_r == OP_ADVANCE && step_r < cfg.eff_total) ||
                (op_r == OP_MOVE && sv_r <= cfg.eff_total)) begin
              step_nxt = (op_r == OP_ADVANCE) ? step_r + 16'd1 : sv_r;
              idx_nxt  = '0;
              if (cfg.n_chan != '0) begin
                re        = 1'b1;
                raddr     = '0;
                state_nxt = ST_RGO;
              end
            end else begin
              rej_nxt = 1'b1;
            end
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_EWAIT: begin
        if (idone) begin
          we             = 1'b1;
          wdata.start_v  = ent_r.cur_v;
          wdata.target_v = val_r;
          wdata.cur_v    = ires;
          if (last_r) begin
            if (chg_r) step_nxt = 16'd1;
            chg_nxt = 1'b0;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_RGO: begin
        ent_nxt   = rdata;
        igo       = 1'b1;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (idone) begin
          we          = 1'b1;
          waddr       = idx_r[CH_W-1:0];
          wdata       = ent_r;
          wdata.cur_v = ires;
          idx_nxt     = idx_r + 1'b1;
          if (idx_nxt < cfg.n_chan) begin
            re        = 1'b1;
            raddr     = idx_nxt[CH_W-1:0];
            state_nxt = ST_RGO;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_cur   = ocur_r;
  assign out_done  = odone_r;
  assign out_rej   = orej_r;

endmodule
